// ===== hw/rtl/owutp_pkg.sv =====
package owutp_pkg;

    // Scratchpad length, check byte included
    localparam int SCRATCH_BYTES_DEF = 9;

    // Bus bytes
    localparam logic [7:0] RESET_BYTE = 8'hF0;
    localparam logic [7:0] SLOT_ONE   = 8'hFF;
    localparam logic [7:0] SLOT_ZERO  = 8'h00;

    // One-wire commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Temperature reported when no sensor answers
    localparam logic signed [11:0] TEMP_NONE = -12'sd990;

    // Input item command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ECHO  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_RST1  = 4'd1,
        PH_SEND1 = 4'd2,
        PH_READ  = 4'd3,
        PH_RST2  = 4'd4,
        PH_SEND2 = 4'd5
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic              tx_send;
        logic [7:0]        tx_byte;
        logic              slow_baud;
        logic              sensor_present;
        logic              temp_update;
        logic signed [11:0] temperature;
        logic              crc_error;
        logic              cycle_done;
    } t_out;

    // Slot byte for one command bit, LSB first
    function automatic logic [7:0] bit_code(input logic [7:0] cmd_byte,
                                            input logic [2:0] idx);
        return cmd_byte[idx] ? SLOT_ONE : SLOT_ZERO;
    endfunction

endpackage

// ===== hw/rtl/owutp_ctrl.sv =====
module owutp_ctrl #(
    parameter int SCRATCH_BYTES = owutp_pkg::SCRATCH_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  owutp_pkg::t_in   i_in,
    output owutp_pkg::t_out  o_res
);

    localparam logic [3:0] LAST_BYTE = 4'(SCRATCH_BYTES - 1);

    owutp_pkg::t_phase r_phase, n_phase;
    logic [2:0]        r_bit, n_bit;
    logic [3:0]        r_byte, n_byte;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_crc, n_crc;
    logic [7:0]        r_low, n_low;
    logic [7:0]        r_high, n_high;
    logic signed [11:0] r_temp, n_temp;
    logic              r_present, n_present;

    logic              echo;
    logic              present_now;
    logic              send_last;
    logic              read_last;
    logic              rx_bit;
    logic              crc_fb;
    logic [7:0]        crc_shifted;
    logic [7:0]        shift_in;
    logic signed [7:0] whole_deg;
    logic signed [11:0] whole_wide;
    logic signed [11:0] temp_x10;
    logic [2:0]        send_bit;
    logic [3:0]        send_byte;
    logic [7:0]        second_cmd;

    assign echo        = (i_in.cmd == owutp_pkg::CMD_ECHO);
    assign present_now = (i_in.rx_byte != owutp_pkg::RESET_BYTE);
    assign send_last   = (r_bit == 3'd7) && (r_byte >= 4'd1);
    assign read_last   = (r_bit == 3'd7) && (r_byte >= LAST_BYTE);

    // Slot decode and CRC bit step
    assign rx_bit      = (i_in.rx_byte == owutp_pkg::SLOT_ONE);
    assign shift_in    = r_shift | (8'(rx_bit) << r_bit);
    assign crc_fb      = r_crc[0] ^ rx_bit;
    assign crc_shifted = {1'b0, r_crc[7:1]} ^ (crc_fb ? owutp_pkg::CRC_POLY : 8'h00);

    // Whole degrees from the middle eight bits of the raw reading, times ten
    assign whole_deg  = {r_high[3:0], r_low[7:4]};
    assign whole_wide = {{4{whole_deg[7]}}, whole_deg};
    assign temp_x10   = (whole_wide <<< 3) + (whole_wide <<< 1);

    // Command bit position after one send step
    assign send_bit   = (r_bit == 3'd7) ? 3'd0 : r_bit + 3'd1;
    assign send_byte  = (r_bit == 3'd7) ? 4'd1 : r_byte;
    assign second_cmd = (r_phase == owutp_pkg::PH_SEND1) ? owutp_pkg::CMD_READ_PAD
                                                         : owutp_pkg::CMD_CONVERT;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            owutp_pkg::PH_IDLE: begin
                if (!echo) n_phase = owutp_pkg::PH_RST1;
            end
            owutp_pkg::PH_RST1: begin
                if (echo) n_phase = present_now ? owutp_pkg::PH_SEND1 : owutp_pkg::PH_RST2;
            end
            owutp_pkg::PH_SEND1: begin
                if (echo && send_last) n_phase = owutp_pkg::PH_READ;
            end
            owutp_pkg::PH_READ: begin
                if (echo && read_last) n_phase = owutp_pkg::PH_RST2;
            end
            owutp_pkg::PH_RST2: begin
                if (echo) n_phase = present_now ? owutp_pkg::PH_SEND2 : owutp_pkg::PH_IDLE;
            end
            owutp_pkg::PH_SEND2: begin
                if (echo && send_last) n_phase = owutp_pkg::PH_IDLE;
            end
            default: n_phase = owutp_pkg::PH_IDLE;
        endcase
    end

    // Datapath and result for this item
    always_comb begin
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_shift   = r_shift;
        n_crc     = r_crc;
        n_low     = r_low;
        n_high    = r_high;
        n_temp    = r_temp;
        n_present = r_present;
        o_res     = '0;

        case (r_phase)
            owutp_pkg::PH_IDLE: begin
                if (!echo) begin
                    n_bit             = 3'd0;
                    n_byte            = 4'd0;
                    o_res.tx_send     = 1'b1;
                    o_res.tx_byte     = owutp_pkg::RESET_BYTE;
                    o_res.slow_baud   = 1'b1;
                end
            end
            owutp_pkg::PH_RST1, owutp_pkg::PH_RST2: begin
                if (echo) begin
                    n_present = present_now;
                    if (present_now) begin
                        n_bit         = 3'd0;
                        n_byte        = 4'd0;
                        o_res.tx_send = 1'b1;
                        o_res.tx_byte = owutp_pkg::bit_code(owutp_pkg::CMD_SKIP_ROM, 3'd0);
                    end else if (r_phase == owutp_pkg::PH_RST1) begin
                        n_temp            = owutp_pkg::TEMP_NONE;
                        o_res.temp_update = 1'b1;
                        o_res.tx_send     = 1'b1;
                        o_res.tx_byte     = owutp_pkg::RESET_BYTE;
                        o_res.slow_baud   = 1'b1;
                    end else begin
                        o_res.cycle_done = 1'b1;
                    end
                end
            end
            owutp_pkg::PH_SEND1, owutp_pkg::PH_SEND2: begin
                if (echo) begin
                    n_bit = send_bit;
                    if (send_last) begin
                        n_byte = 4'd0;
                        if (r_phase == owutp_pkg::PH_SEND1) begin
                            n_crc         = 8'h00;
                            n_shift       = 8'h00;
                            o_res.tx_send = 1'b1;
                            o_res.tx_byte = owutp_pkg::SLOT_ONE;
                        end else begin
                            o_res.cycle_done = 1'b1;
                        end
                    end else begin
                        n_byte        = send_byte;
                        o_res.tx_send = 1'b1;
                        o_res.tx_byte = owutp_pkg::bit_code(
                            (send_byte == 4'd0) ? owutp_pkg::CMD_SKIP_ROM : second_cmd,
                            send_bit);
                    end
                end
            end
            owutp_pkg::PH_READ: begin
                if (echo) begin
                    n_shift = shift_in;
                    if (r_byte < LAST_BYTE) n_crc = crc_shifted;
                    o_res.tx_send = 1'b1;
                    o_res.tx_byte = owutp_pkg::SLOT_ONE;
                    if (r_bit != 3'd7) begin
                        n_bit = r_bit + 3'd1;
                    end else begin
                        n_bit   = 3'd0;
                        n_shift = 8'h00;
                        if (r_byte == 4'd0) n_low  = shift_in;
                        if (r_byte == 4'd1) n_high = shift_in;
                        if (r_byte >= LAST_BYTE) begin
                            // check byte: compare, then open the second reset
                            n_byte = 4'd0;
                            if (r_crc == shift_in) begin
                                n_temp            = temp_x10;
                                o_res.temp_update = 1'b1;
                            end else begin
                                o_res.crc_error = 1'b1;
                            end
                            o_res.tx_byte   = owutp_pkg::RESET_BYTE;
                            o_res.slow_baud = 1'b1;
                        end else begin
                            n_byte = r_byte + 4'd1;
                        end
                    end
                end
            end
            default: ;
        endcase

        o_res.sensor_present = n_present;
        o_res.temperature    = n_temp;
    end

    // Hold state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= owutp_pkg::PH_IDLE;
            r_bit     <= 3'd0;
            r_byte    <= 4'd0;
            r_shift   <= 8'h00;
            r_crc     <= 8'h00;
            r_low     <= 8'h00;
            r_high    <= 8'h00;
            r_temp    <= owutp_pkg::TEMP_NONE;
            r_present <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_shift   <= n_shift;
            r_crc     <= n_crc;
            r_low     <= n_low;
            r_high    <= n_high;
            r_temp    <= n_temp;
            r_present <= n_present;
        end
    end

`ifndef SYNTHESIS
    // An echo while idle leaves the block idle
    a_idle_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == owutp_pkg::PH_IDLE && echo |=> r_phase == owutp_pkg::PH_IDLE)
        else $error("echo while idle left the idle phase");

    // A check byte mismatch moves on to the second reset
    a_crc_rst2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.crc_error |=> r_phase == owutp_pkg::PH_RST2)
        else $error("crc error did not lead to second reset");

    // Temperature changes only on an item that flags an update
    a_temp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !o_res.temp_update |=> r_temp == $past(r_temp))
        else $error("temperature changed without update flag");
`endif

endmodule

// ===== hw/rtl/onewire_uart_thermometer_poller.sv =====
// One-wire thermometer poller over a UART. Send a start item (cmd 0) to open a poll
// cycle and feed back every echoed UART byte as an item with cmd 1; each item yields
// exactly one result telling what to transmit next, at which baud, and the current
// presence, temperature (tenths of a degree, -990 with no sensor) and status flags.
// One item is taken per clock cycle; its result is held in the output register from the
// cycle after acceptance, and input is stalled only while that register is full and
// the receiver stalls it. All the per-item work, the CRC bit step included, is one
// pass of logic between the state registers and the output register.
module onewire_uart_thermometer_poller #(
    parameter int SCRATCH_BYTES = owutp_pkg::SCRATCH_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  owutp_pkg::t_in   i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output owutp_pkg::t_out  o_out
);

    logic            step;
    logic            r_out_valid, n_out_valid;
    owutp_pkg::t_out r_out;
    owutp_pkg::t_out res;

    // Accept while the output register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign step       = i_in_valid && !o_in_stall;

    owutp_ctrl #(
        .SCRATCH_BYTES(SCRATCH_BYTES)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (step),
        .i_in   (i_in),
        .o_res  (res)
    );

    // Hold the result until taken
    assign n_out_valid = step || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
